### rtl/core/mtep_pkg.sv
package mtep_pkg;

  // Kinds of reported events.
  typedef enum logic [2:0] {
    EvNoteOn      = 3'd0,
    EvNoteOff     = 3'd1,
    EvTempo       = 3'd2,
    EvEndOfTrack  = 3'd3,
    EvNoStatus    = 3'd4,
    EvBadStatus   = 3'd5
  } event_kind_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned NoteW   = 7;
  localparam int unsigned TempoW  = 24;
  localparam int unsigned BpmW    = 26;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DeltaW  = 28;

  // Status high nibbles.
  localparam logic [3:0] StNoteOff  = 4'h8;
  localparam logic [3:0] StNoteOn   = 4'h9;
  localparam logic [3:0] StControl  = 4'hB;
  localparam logic [3:0] StProgram  = 4'hC;
  localparam logic [3:0] StBend     = 4'hE;
  localparam logic [3:0] StSystem   = 4'hF;

  localparam logic [ByteW-1:0] SysexEnd     = 8'hF7;
  localparam logic [ByteW-1:0] MetaEndTrack = 8'h2F;
  localparam logic [ByteW-1:0] MetaTempo    = 8'h51;

  localparam logic [BpmW-1:0]   UsPerMinute  = 26'd60000000;
  localparam logic [TempoW-1:0] TempoDefault = 24'd500000;

endpackage

### rtl/core/mtep_byte_if.sv
interface mtep_byte_if;
  logic                        valid;
  logic                        ready;
  logic [mtep_pkg::ByteW-1:0]  track_byte;
  logic                        track_start;

  modport source (output valid, output track_byte, output track_start, input ready);
  modport sink   (input valid, input track_byte, input track_start, output ready);
endinterface

### rtl/core/mtep_event_if.sv
interface mtep_event_if;
  logic                          valid;
  logic                          ready;
  mtep_pkg::event_kind_e         event_kind;
  logic [mtep_pkg::ChanW-1:0]    channel;
  logic [mtep_pkg::NoteW-1:0]    note_number;
  logic [mtep_pkg::NoteW-1:0]    velocity;
  logic [mtep_pkg::TempoW-1:0]   tempo_us;
  logic [mtep_pkg::BpmW-1:0]     beats_per_minute;
  logic [mtep_pkg::TimeW-1:0]    event_time;

  modport source (output valid, output event_kind, output channel, output note_number,
                  output velocity, output tempo_us, output beats_per_minute,
                  output event_time, input ready);
  modport sink   (input valid, input event_kind, input channel, input note_number,
                  input velocity, input tempo_us, input beats_per_minute,
                  input event_time, output ready);
endinterface

### rtl/core/midi_track_event_parser.sv
// Channel  | Direction | Transaction
// track_i  | in        | one byte of track chunk data, with a new-track flag
// event_o  | out       | one decoded event (note, tempo, end of track, error)
//
// Each byte is decoded as it is taken. A tempo event with a changed, nonzero
// tempo then runs the restoring divider (one quotient bit a cycle), during
// which no byte is taken. A byte is taken when the divider is idle and
// the output register is empty or being emptied in the same cycle.
// Reset is asynchronous and clears all parser state; the tempo returns to 500000.
module midi_track_event_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mtep_byte_if.sink            track_i,
  mtep_event_if.source         event_o
);

  localparam logic [3:0] PhDelta   = 4'd0;
  localparam logic [3:0] PhStatus  = 4'd1;
  localparam logic [3:0] PhNoteKey = 4'd2;
  localparam logic [3:0] PhNoteVel = 4'd3;
  localparam logic [3:0] PhSkip    = 4'd4;
  localparam logic [3:0] PhSysex   = 4'd5;
  localparam logic [3:0] PhMetaTyp = 4'd6;
  localparam logic [3:0] PhMetaLen = 4'd7;
  localparam logic [3:0] PhTempo   = 4'd8;
  localparam logic [3:0] PhError   = 4'd9;
  localparam logic [3:0] PhDone    = 4'd10;

  localparam int unsigned ByteW  = mtep_pkg::ByteW;
  localparam int unsigned TempoW = mtep_pkg::TempoW;
  localparam int unsigned BpmW   = mtep_pkg::BpmW;
  localparam int unsigned TimeW  = mtep_pkg::TimeW;
  localparam int unsigned DeltaW = mtep_pkg::DeltaW;
  localparam int unsigned NoteW  = mtep_pkg::NoteW;
  localparam int unsigned ChanW  = mtep_pkg::ChanW;
  localparam int unsigned CntW   = $clog2(BpmW);

  // Parser state.
  logic [3:0]        phase_q, phase_d;
  logic [ByteW-1:0]  status_q, status_d;
  logic [TimeW-1:0]  abs_time_q, abs_time_d;
  logic [DeltaW-1:0] delta_q, delta_d;
  logic [NoteW-1:0]  first_q, first_d;
  logic [ByteW-1:0]  meta_type_q, meta_type_d;
  logic [ByteW-1:0]  skip_q, skip_d;
  logic [TempoW-1:0] tempo_build_q, tempo_build_d;
  logic [TempoW-1:0] cur_tempo_q, cur_tempo_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  mtep_pkg::event_kind_e out_kind_q;
  logic [ChanW-1:0]      out_chan_q;
  logic [NoteW-1:0]      out_note_q;
  logic [NoteW-1:0]      out_vel_q;
  logic [TempoW-1:0]     out_tempo_q;
  logic [BpmW-1:0]       out_bpm_q;
  logic [TimeW-1:0]      out_time_q;

  // Divider.
  logic              div_busy_q;
  logic [CntW-1:0]   div_cnt_q;
  logic [TempoW-1:0] div_rem_q;
  logic [BpmW-1:0]   div_quo_q;
  logic [TempoW:0]   div_trial;
  logic [TempoW+1:0] div_diff;
  logic              div_ge;
  logic [TempoW-1:0] div_rem_next;
  logic [BpmW-1:0]   div_quo_next;
  logic              div_last;

  // Per-byte decode results.
  logic                  in_fire;
  logic                  emit;
  logic                  div_start;
  mtep_pkg::event_kind_e emit_kind;
  logic [ChanW-1:0]      emit_chan;
  logic [NoteW-1:0]      emit_note;
  logic [NoteW-1:0]      emit_vel;
  logic [TempoW-1:0]     emit_tempo;
  logic                  run_event;
  logic                  is_data;
  logic [ByteW-1:0]      b;
  logic [TimeW:0]        time_sum;
  logic [TempoW-1:0]     tempo_next;

  assign in_fire       = track_i.valid && track_i.ready;
  assign track_i.ready = !div_busy_q && (!out_valid_q || event_o.ready);
  assign b             = track_i.track_byte;

  always_comb begin
    phase_d       = phase_q;
    status_d      = status_q;
    abs_time_d    = abs_time_q;
    delta_d       = delta_q;
    first_d       = first_q;
    meta_type_d   = meta_type_q;
    skip_d        = skip_q;
    tempo_build_d = tempo_build_q;
    cur_tempo_d   = cur_tempo_q;
    emit          = 1'b0;
    div_start     = 1'b0;
    emit_kind     = mtep_pkg::EvNoteOn;
    emit_chan     = '0;
    emit_note     = '0;
    emit_vel      = '0;
    emit_tempo    = '0;
    run_event     = 1'b0;
    is_data       = !b[ByteW-1];
    time_sum      = '0;
    tempo_next    = '0;

    if (in_fire) begin
      if (track_i.track_start) begin
        phase_d       = PhDelta;
        status_d      = '0;
        abs_time_d    = '0;
        delta_d       = '0;
        first_d       = '0;
        meta_type_d   = '0;
        skip_d        = '0;
        tempo_build_d = '0;
      end

      if (phase_d == PhDone || phase_d == PhError) begin
        run_event = 1'b0;
      end else if (phase_d == PhDelta) begin
        delta_d = {delta_d[DeltaW-8:0], b[6:0]};
        if (is_data) begin
          // Saturating add of the finished delta time.
          time_sum = {1'b0, abs_time_d} + {{(TimeW+1-DeltaW){1'b0}}, delta_d};
          abs_time_d = time_sum[TimeW] ? {TimeW{1'b1}} : time_sum[TimeW-1:0];
          delta_d = '0;
          phase_d = PhStatus;
        end
      end else begin
        run_event = 1'b1;
        if (phase_d == PhStatus) begin
          // A data byte under running status is also the first byte of the event.
          run_event = is_data;
          if (is_data && !status_d[ByteW-1]) begin
            phase_d   = PhError;
            emit      = 1'b1;
            emit_kind = mtep_pkg::EvNoStatus;
          end else begin
            if (!is_data) begin
              status_d = b;
            end
            unique case (status_d[7:4])
              mtep_pkg::StNoteOff, mtep_pkg::StNoteOn: begin
                phase_d = PhNoteKey;
              end
              mtep_pkg::StControl, mtep_pkg::StBend: begin
                skip_d  = 8'd2;
                phase_d = PhSkip;
              end
              mtep_pkg::StProgram: begin
                skip_d  = 8'd1;
                phase_d = PhSkip;
              end
              mtep_pkg::StSystem: begin
                phase_d = (status_d[3:0] == 4'h0) ? PhSysex : PhMetaTyp;
              end
              default: begin
                phase_d   = PhError;
                emit      = 1'b1;
                emit_kind = mtep_pkg::EvBadStatus;
                run_event = 1'b0;
              end
            endcase
          end
        end

        if (run_event) begin
          unique case (phase_d)
            PhNoteKey: begin
              first_d = b[NoteW-1:0];
              phase_d = PhNoteVel;
            end
            PhNoteVel: begin
              phase_d   = PhDelta;
              emit      = 1'b1;
              emit_chan = status_d[3:0];
              emit_note = first_d;
              if (status_d[7:4] == mtep_pkg::StNoteOn && b[NoteW-1:0] != '0) begin
                emit_kind = mtep_pkg::EvNoteOn;
                emit_vel  = b[NoteW-1:0];
              end else begin
                emit_kind = mtep_pkg::EvNoteOff;
              end
            end
            PhSkip: begin
              if (skip_d != '0) begin
                skip_d = skip_d - 8'd1;
              end
              if (skip_d == '0) begin
                phase_d = PhDelta;
              end
            end
            PhSysex: begin
              if (b == mtep_pkg::SysexEnd) begin
                phase_d = PhDelta;
              end
            end
            PhMetaTyp: begin
              meta_type_d = b;
              phase_d     = PhMetaLen;
            end
            PhMetaLen: begin
              if (meta_type_d == mtep_pkg::MetaEndTrack) begin
                phase_d   = PhDone;
                emit      = 1'b1;
                emit_kind = mtep_pkg::EvEndOfTrack;
              end else if (meta_type_d == mtep_pkg::MetaTempo) begin
                // Exactly three tempo bytes follow, whatever the length says.
                tempo_build_d = '0;
                skip_d        = 8'd3;
                phase_d       = PhTempo;
              end else begin
                skip_d  = b;
                phase_d = (b == '0) ? PhDelta : PhSkip;
              end
            end
            PhTempo: begin
              tempo_next    = {tempo_build_d[TempoW-9:0], b};
              tempo_build_d = tempo_next;
              if (skip_d != '0) begin
                skip_d = skip_d - 8'd1;
              end
              if (skip_d == '0) begin
                phase_d = PhDelta;
                if (tempo_next != cur_tempo_d) begin
                  cur_tempo_d = tempo_next;
                  emit_kind   = mtep_pkg::EvTempo;
                  emit_tempo  = tempo_next;
                  // A zero tempo reports zero without a division.
                  if (tempo_next == '0) begin
                    emit = 1'b1;
                  end else begin
                    div_start = 1'b1;
                  end
                end
              end
            end
            default: begin
              phase_d = PhError;
            end
          endcase
        end
      end
    end
  end

  // One restoring division step per cycle: 60000000 / current tempo.
  assign div_trial    = {div_rem_q, div_quo_q[BpmW-1]};
  assign div_diff     = {1'b0, div_trial} - {2'b00, cur_tempo_q};
  assign div_ge       = !div_diff[TempoW+1];
  assign div_rem_next = div_ge ? div_diff[TempoW-1:0] : div_trial[TempoW-1:0];
  assign div_quo_next = {div_quo_q[BpmW-2:0], div_ge};
  assign div_last     = div_busy_q && (div_cnt_q == '0);

  always_comb begin
    out_valid_d = out_valid_q;
    if (event_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit || div_last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhDelta;
      status_q      <= '0;
      abs_time_q    <= '0;
      delta_q       <= '0;
      first_q       <= '0;
      meta_type_q   <= '0;
      skip_q        <= '0;
      tempo_build_q <= '0;
      cur_tempo_q   <= mtep_pkg::TempoDefault;
      out_valid_q   <= 1'b0;
      div_busy_q    <= 1'b0;
      div_cnt_q     <= '0;
    end else begin
      phase_q       <= phase_d;
      status_q      <= status_d;
      abs_time_q    <= abs_time_d;
      delta_q       <= delta_d;
      first_q       <= first_d;
      meta_type_q   <= meta_type_d;
      skip_q        <= skip_d;
      tempo_build_q <= tempo_build_d;
      cur_tempo_q   <= cur_tempo_d;
      out_valid_q   <= out_valid_d;
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= CntW'(BpmW - 1);
      end else if (div_last) begin
        div_busy_q <= 1'b0;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= mtep_pkg::UsPerMinute;
    end else if (div_busy_q) begin
      div_rem_q <= div_rem_next;
      div_quo_q <= div_quo_next;
    end
    // The output register is free whenever a byte is taken, so a tempo
    // transaction loads its fields at the start and its quotient at the end.
    if (emit || div_start) begin
      out_kind_q  <= emit_kind;
      out_chan_q  <= emit_chan;
      out_note_q  <= emit_note;
      out_vel_q   <= emit_vel;
      out_tempo_q <= emit_tempo;
      out_bpm_q   <= '0;
      out_time_q  <= abs_time_d;
    end else if (div_last) begin
      out_bpm_q <= div_quo_next;
    end
  end

  assign event_o.valid            = out_valid_q;
  assign event_o.event_kind       = out_kind_q;
  assign event_o.channel          = out_chan_q;
  assign event_o.note_number      = out_note_q;
  assign event_o.velocity         = out_vel_q;
  assign event_o.tempo_us         = out_tempo_q;
  assign event_o.beats_per_minute = out_bpm_q;
  assign event_o.event_time       = out_time_q;

endmodule
